// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that use the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define DIFC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define DIFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/difc_pkg.sv =====
// ----------------------------------------------------------------------------
// difc_pkg
// Types and constants shared by the display idle fade controller modules.
// ----------------------------------------------------------------------------
package difc_pkg;

  // Event codes carried by an input beat.
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_ACTIVITY   = 3'd1,
    OP_WAKE_PRESS = 3'd2,
    OP_WAKE       = 3'd3,
    OP_SLEEP      = 3'd4,
    OP_INIT       = 3'd5
  } op_e;

  // Display modes.
  typedef enum logic [1:0] {
    MODE_AWAKE      = 2'd0,
    MODE_FADING_OUT = 2'd1,
    MODE_ASLEEP     = 2'd2,
    MODE_FADING_IN  = 2'd3
  } mode_e;

  // Panel power commands.
  typedef enum logic [1:0] {
    PANEL_NONE      = 2'd0,
    PANEL_SLEEP_IN  = 2'd1,
    PANEL_SLEEP_OUT = 2'd2
  } panel_cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_FULL      = 3'd1;
  localparam logic [2:0] CFG_FADE_OUT  = 3'd2;
  localparam logic [2:0] CFG_FADE_IN   = 3'd3;
  localparam logic [2:0] CFG_FADE_STEP = 3'd4;
  localparam logic [2:0] CFG_SLEEP_USB = 3'd5;

  // Configuration reset values.
  localparam logic [31:0] RST_TIMEOUT   = 32'd30000;
  localparam logic [7:0]  RST_FULL      = 8'd255;
  localparam logic [15:0] RST_FADE_OUT  = 16'd500;
  localparam logic [15:0] RST_FADE_IN   = 16'd200;
  localparam logic [15:0] RST_FADE_STEP = 16'd20;

  // Brightness ceiling and divider widths.
  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam int unsigned DIV_NUM_W = 24;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned DIV_CNT_W = 5;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic        vbus_in;
  } in_item_t;

  typedef struct packed {
    logic       set_level;
    logic [7:0] level;
    panel_cmd_e panel_cmd;
    logic       press_consumed;
    logic       is_asleep;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic fin;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/core/difc_div.sv =====
// ----------------------------------------------------------------------------
// difc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module difc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [difc_pkg::DIV_NUM_W-1:0]      num_i,
  input  logic [difc_pkg::DIV_DEN_W-1:0]      den_i,
  output logic                                done_o,
  output logic [difc_pkg::DIV_NUM_W-1:0]      quo_o
);
  import difc_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  // One shift-and-subtract step.
  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_d   = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    quo_d   = {quo_q[DIV_NUM_W-2:0], ge};
    cnt_d   = cnt_q - 1'b1;
    busy_d  = (cnt_q != '0);
    done_d  = (cnt_q == '0);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
    end else if (busy_q) begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/difc_datapath.sv =====
// ----------------------------------------------------------------------------
// difc_datapath
// Configuration, display state, event evaluation and fade interpolation.
// ----------------------------------------------------------------------------
module difc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [31:0]           cfg_wdata_i,
  input  difc_pkg::in_item_t    in_data_i,
  input  difc_pkg::ctrl_cmd_t   cmd_i,
  output difc_pkg::dp_status_t  status_o,
  output difc_pkg::out_item_t   res_o
);
  import difc_pkg::*;

  // Configuration registers.
  logic [31:0] timeout_q;
  logic [7:0]  full_q;
  logic [15:0] fade_out_q;
  logic [15:0] fade_in_q;
  logic [15:0] fade_step_q;
  logic        sleep_usb_q;

  // Display state.
  mode_e       mode_q, mode_d;
  logic [31:0] last_act_q, last_act_d;
  logic [31:0] fstart_q, fstart_d;
  logic [31:0] flast_q, flast_d;
  logic [7:0]  fsrc_q, fsrc_d;
  logic [7:0]  ftgt_q, ftgt_d;
  logic        poff_q, poff_d;
  logic        uslept_q, uslept_d;

  // Captured item, interpolation operands and result.
  in_item_t          item_q;
  logic signed [8:0] span_q, span_d;
  logic [15:0]       elap_q, elap_d;
  logic [15:0]       dur_q, dur_d;
  logic              neg_q;
  out_item_t         res_q, res_d;
  logic              need_div;

  // Evaluation temporaries.
  logic        dark;
  logic        go_wake;
  logic        go_dark;
  logic        auto_sleep;
  logic [31:0] now;
  logic [31:0] since_act;
  logic [31:0] since_upd;
  logic [31:0] elapsed;
  logic [15:0] dur;

  // Multiply and final level.
  logic signed [25:0]    prod;
  logic [25:0]           mag_full;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  quo;
  logic signed [25:0]    qs;
  logic signed [25:0]    lvl_s;
  logic [7:0]            lvl_div;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= RST_TIMEOUT;
      full_q      <= RST_FULL;
      fade_out_q  <= RST_FADE_OUT;
      fade_in_q   <= RST_FADE_IN;
      fade_step_q <= RST_FADE_STEP;
      sleep_usb_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i;
        CFG_FULL:      full_q      <= cfg_wdata_i[7:0];
        CFG_FADE_OUT:  fade_out_q  <= cfg_wdata_i[15:0];
        CFG_FADE_IN:   fade_in_q   <= cfg_wdata_i[15:0];
        CFG_FADE_STEP: fade_step_q <= cfg_wdata_i[15:0];
        CFG_SLEEP_USB: sleep_usb_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Event evaluation: everything but the interpolation multiply and divide.
  always_comb begin
    mode_d     = mode_q;
    last_act_d = last_act_q;
    fstart_d   = fstart_q;
    flast_d    = flast_q;
    fsrc_d     = fsrc_q;
    ftgt_d     = ftgt_q;
    poff_d     = poff_q;
    uslept_d   = uslept_q;
    res_d      = '0;
    res_d.panel_cmd = PANEL_NONE;
    need_div   = 1'b0;
    span_d     = '0;
    elap_d     = '0;
    dur_d      = '0;
    go_wake    = 1'b0;
    go_dark    = 1'b0;
    auto_sleep = 1'b0;
    now        = item_q.now_ms;
    dark       = (mode_q == MODE_ASLEEP) || (mode_q == MODE_FADING_OUT);

    case (op_e'(item_q.op)) inside
      OP_TICK: begin
        if (!sleep_usb_q && item_q.vbus_in) begin
          last_act_d = now;
          if (!uslept_q && dark) begin
            go_wake = 1'b1;
          end
        end
      end
      OP_ACTIVITY, OP_WAKE: begin
        last_act_d = now;
        if (dark) begin
          go_wake = 1'b1;
        end
      end
      OP_WAKE_PRESS: begin
        last_act_d = now;
        if (dark) begin
          go_wake = 1'b1;
          res_d.press_consumed = 1'b1;
        end else if (mode_q == MODE_FADING_IN) begin
          res_d.press_consumed = 1'b1;
        end
      end
      OP_SLEEP: begin
        if (!dark) begin
          uslept_d = 1'b1;
          go_dark  = 1'b1;
        end
      end
      OP_INIT: begin
        mode_d          = MODE_AWAKE;
        last_act_d      = now;
        res_d.set_level = 1'b1;
        res_d.level     = full_q;
      end
      default: ;
    endcase

    // Inactivity timeout on a tick while awake.
    since_act = now - last_act_d;
    if ((op_e'(item_q.op) == OP_TICK) && (mode_q == MODE_AWAKE) &&
        (timeout_q != '0) && (since_act >= timeout_q)) begin
      auto_sleep = 1'b1;
    end

    // Start a fade toward full brightness.
    if (go_wake) begin
      if (full_q != '0) begin
        uslept_d = 1'b0;
        if (poff_q) begin
          res_d.panel_cmd = PANEL_SLEEP_OUT;
          poff_d          = 1'b0;
        end
      end
      fsrc_d   = '0;
      ftgt_d   = full_q;
      fstart_d = now;
      flast_d  = now;
      mode_d   = MODE_FADING_IN;
    end

    // Start a fade toward dark.
    if (go_dark || auto_sleep) begin
      fsrc_d   = full_q;
      ftgt_d   = '0;
      fstart_d = now;
      flast_d  = now;
      mode_d   = MODE_FADING_OUT;
    end

    // Fade progress on a tick.
    since_upd = now - flast_d;
    elapsed   = now - fstart_d;
    dur       = (mode_d == MODE_FADING_OUT) ? fade_out_q : fade_in_q;
    if ((op_e'(item_q.op) == OP_TICK) && !auto_sleep &&
        ((mode_d == MODE_FADING_OUT) || (mode_d == MODE_FADING_IN)) &&
        (since_upd >= {16'b0, fade_step_q})) begin
      flast_d = now;
      if (elapsed >= {16'b0, dur}) begin
        res_d.set_level = 1'b1;
        res_d.level     = ftgt_d;
        if (mode_d == MODE_FADING_OUT) begin
          mode_d          = MODE_ASLEEP;
          res_d.panel_cmd = PANEL_SLEEP_IN;
          poff_d          = 1'b1;
        end else begin
          mode_d = MODE_AWAKE;
        end
      end else begin
        need_div = 1'b1;
        span_d   = $signed({1'b0, ftgt_d}) - $signed({1'b0, fsrc_d});
        elap_d   = elapsed[15:0];
        dur_d    = dur;
      end
    end

    res_d.is_asleep = (mode_d == MODE_ASLEEP) || (mode_d == MODE_FADING_OUT);
  end

  // Display state commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_AWAKE;
      last_act_q <= '0;
      fstart_q   <= '0;
      flast_q    <= '0;
      fsrc_q     <= RST_FULL;
      ftgt_q     <= '0;
      poff_q     <= 1'b0;
      uslept_q   <= 1'b0;
    end else if (cmd_i.eval) begin
      mode_q     <= mode_d;
      last_act_q <= last_act_d;
      fstart_q   <= fstart_d;
      flast_q    <= flast_d;
      fsrc_q     <= fsrc_d;
      ftgt_q     <= ftgt_d;
      poff_q     <= poff_d;
      uslept_q   <= uslept_d;
    end
  end

  // Signed product of span and elapsed time, then its magnitude.
  always_comb begin
    prod     = $signed({{17{span_q[8]}}, span_q}) * $signed({10'b0, elap_q});
    mag_full = prod[25] ? (26'd0 - prod) : prod;
  end

  difc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul),
    .num_i   (mag_full[DIV_NUM_W-1:0]),
    .den_i   (dur_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Interpolated level with clamping.
  always_comb begin
    qs    = neg_q ? (26'sd0 - $signed({2'b0, quo})) : $signed({2'b0, quo});
    lvl_s = $signed({18'b0, fsrc_q}) + qs;
    if (lvl_s < 0) begin
      lvl_div = '0;
    end else if (lvl_s > $signed({18'b0, LEVEL_MAX})) begin
      lvl_div = LEVEL_MAX;
    end else begin
      lvl_div = lvl_s[7:0];
    end
  end

  // Item capture, interpolation operands and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.eval) begin
      res_q  <= res_d;
      span_q <= span_d;
      elap_q <= elap_d;
      dur_q  <= dur_d;
    end
    if (cmd_i.mul) begin
      neg_q <= prod[25];
    end
    if (cmd_i.fin) begin
      res_q.set_level <= 1'b1;
      res_q.level     <= lvl_div;
    end
  end

  assign status_o.need_div = need_div;
  assign status_o.div_done = div_done;
  assign res_o             = res_q;

endmodule

// ===== rtl/core/difc_ctrl.sv =====
// ----------------------------------------------------------------------------
// difc_ctrl
// Sequencer for one event: capture, evaluate, optional multiply and divide, deliver.
// ----------------------------------------------------------------------------
module difc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  difc_pkg::dp_status_t  status_i,
  output difc_pkg::ctrl_cmd_t   cmd_o
);
  import difc_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.need_div ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/display_idle_fade_controller.sv =====
// ----------------------------------------------------------------------------
// display_idle_fade_controller
// Display idle controller: auto sleep on inactivity, linear brightness fades
// and panel sleep-in / sleep-out commands.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one event (tick, activity, wake press, wake,
// manual sleep or init) with the millisecond time and the USB power flag.
// Every input beat yields exactly one output beat with the brightness update,
// panel command, press-consumed flag and the asleep flag.
// Sequence: an event that needs no interpolation is captured, evaluated and
// then delivered. A fade tick that interpolates is also multiplied and run
// through the radix-2 divider over all 24 quotient bits before delivery.
// One event is processed at a time, so no new beat is accepted until the
// result of the last one has been taken.
// Configuration is a plain write port, taken at any edge with cfg_we_i high;
// write only while no event is in flight.
// Reset returns the mode to awake and the configuration and display state registers to their default values.
// A result is held in the output register until the receiver takes it; while
// the receiver stalls no new input beat is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module display_idle_fade_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  difc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output difc_pkg::out_item_t  out_data_o
);
  import difc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  difc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  difc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (out_data_o)
  );

  // Only one event is in flight at a time.
  `DIFC_ASSERT_SAME(a_one_in_flight, out_valid_o, !in_ready_o, "input ready while result pending")
  // An accepted beat never produces its result in the next cycle.
  `DIFC_ASSERT_NEXT(a_no_early_result, in_valid_i && in_ready_o, !out_valid_o, "result too early")
  // A sleep-in command always leaves the display asleep.
  `DIFC_ASSERT_SAME(a_sleep_in_dark, out_valid_o && (out_data_o.panel_cmd == PANEL_SLEEP_IN), out_data_o.is_asleep, "sleep-in while not asleep")
  // A consumed wake press always leaves the display lit or lighting.
  `DIFC_ASSERT_SAME(a_press_wakes, out_valid_o && out_data_o.press_consumed, !out_data_o.is_asleep, "consumed press while asleep")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the display idle fade controller. A scoreboard
// class mirrors the mode, activity clock and fade state of the block and
// predicts the one result of every accepted event beat. A short directed
// sequence walks through timeout, fade-out, manual sleep, USB and press wakes,
// and time wrap. Random phases then run event streams with advancing time
// under several register settings, including zero and full-scale values, and
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import difc_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 7;
  localparam int PHASE_ITEMS    = 112;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 32;
  localparam int LIMIT_CYCLES   = 1500000;
  localparam int REPORT_LIMIT   = 10;

  // Event codes that the block does not define.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  // Register index past the last defined register.
  localparam logic [2:0] CFG_SPARE  = 3'd7;

  // Register settings as the predictor sees them.
  typedef struct packed {
    logic [31:0] timeout;
    logic [7:0]  full;
    logic [15:0] fade_out;
    logic [15:0] fade_in;
    logic [15:0] step_gap;
    logic        usb_sleep;
  } fade_cfg_t;

  // --------------------------------------------------------------------------
  // Scoreboard: fade predictor plus the queue of expected results.
  // --------------------------------------------------------------------------
  class fade_scoreboard;
    fade_cfg_t   cfg;
    mode_e       mode;
    logic [31:0] last_act;
    logic [31:0] fade_t0;
    logic [31:0] fade_prev;
    logic [7:0]  ramp_src;
    logic [7:0]  fade_to;
    logic        panel_dark;
    logic        user_sleep;
    out_item_t   res;
    out_item_t   expected_q[$];
    int          results_seen;
    int          faults;

    function new();
      cfg.timeout   = RST_TIMEOUT;
      cfg.full      = RST_FULL;
      cfg.fade_out  = RST_FADE_OUT;
      cfg.fade_in   = RST_FADE_IN;
      cfg.step_gap  = RST_FADE_STEP;
      cfg.usb_sleep = 1'b0;
      mode          = MODE_AWAKE;
      last_act      = '0;
      fade_t0       = '0;
      fade_prev     = '0;
      ramp_src      = RST_FULL;
      fade_to       = '0;
      panel_dark    = 1'b0;
      user_sleep    = 1'b0;
      results_seen  = 0;
      faults        = 0;
    endfunction

    function bit dark();
      return mode == MODE_ASLEEP || mode == MODE_FADING_OUT;
    endfunction

    function void emit(logic [7:0] lvl);
      res.set_level = 1'b1;
      res.level     = lvl;
    endfunction

    // A fade toward a nonzero level also powers the panel back up.
    function void start_ramp(logic [7:0] target, logic [31:0] stamp);
      if (target != 8'd0) begin
        user_sleep = 1'b0;
        if (panel_dark) begin
          res.panel_cmd = PANEL_SLEEP_OUT;
          panel_dark    = 1'b0;
        end
      end
      ramp_src  = (target == 8'd0) ? cfg.full : 8'd0;
      fade_to   = target;
      fade_t0   = stamp;
      fade_prev = stamp;
    endfunction

    function void wake_up(logic [31:0] stamp);
      start_ramp(cfg.full, stamp);
      mode = MODE_FADING_IN;
    endfunction

    function void tick(logic [31:0] stamp, logic vbus);
      logic [31:0] idle_ms;
      logic [31:0] since_upd;
      logic [31:0] elapsed;
      logic [15:0] dur;
      int          span;
      int          prod;
      int unsigned mag;
      int          q;
      int          lvl;
      // USB power counts as activity unless sleeping on USB is allowed.
      if (!cfg.usb_sleep && vbus) begin
        last_act = stamp;
        if (!user_sleep && dark()) wake_up(stamp);
      end
      if (mode == MODE_AWAKE) begin
        idle_ms = stamp - last_act;
        if (cfg.timeout != 32'd0 && idle_ms >= cfg.timeout) begin
          start_ramp(8'd0, stamp);
          mode = MODE_FADING_OUT;
        end
      end else if (mode == MODE_FADING_OUT || mode == MODE_FADING_IN) begin
        since_upd = stamp - fade_prev;
        if (since_upd >= cfg.step_gap) begin
          fade_prev = stamp;
          dur       = (mode == MODE_FADING_OUT) ? cfg.fade_out : cfg.fade_in;
          elapsed   = stamp - fade_t0;
          if (elapsed >= dur) begin
            emit(fade_to);
            if (mode == MODE_FADING_OUT) begin
              mode          = MODE_ASLEEP;
              res.panel_cmd = PANEL_SLEEP_IN;
              panel_dark    = 1'b1;
            end else begin
              mode = MODE_AWAKE;
            end
          end else begin
            // Linear interpolation with division truncated toward zero.
            span = int'(fade_to) - int'(ramp_src);
            prod = span * int'(elapsed);
            mag  = (prod < 0) ? -prod : prod;
            q    = int'(mag / dur);
            if (prod < 0) q = -q;
            lvl = int'(ramp_src) + q;
            if (lvl < 0) lvl = 0;
            if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
            emit(lvl[7:0]);
          end
        end
      end
    endfunction

    // Advance the predictor by one accepted event beat.
    function void note_event(in_item_t beat);
      res = '0;
      case (beat.op) inside
        OP_TICK: tick(beat.now_ms, beat.vbus_in);
        OP_ACTIVITY, OP_WAKE: begin
          last_act = beat.now_ms;
          if (dark()) wake_up(beat.now_ms);
        end
        OP_WAKE_PRESS: begin
          last_act = beat.now_ms;
          if (dark()) begin
            wake_up(beat.now_ms);
            res.press_consumed = 1'b1;
          end else if (mode == MODE_FADING_IN) begin
            res.press_consumed = 1'b1;
          end
        end
        OP_SLEEP: begin
          if (!dark()) begin
            user_sleep = 1'b1;
            start_ramp(8'd0, beat.now_ms);
            mode = MODE_FADING_OUT;
          end
        end
        OP_INIT: begin
          mode     = MODE_AWAKE;
          last_act = beat.now_ms;
          emit(cfg.full);
        end
        default: ;
      endcase
      res.is_asleep = dark();
      expected_q.push_back(res);
    endfunction

    function string show(out_item_t r);
      return $sformatf("set=%0d level=%0d cmd=%0d consumed=%0d asleep=%0d",
                       r.set_level, r.level, r.panel_cmd, r.press_consumed, r.is_asleep);
    endfunction

    function void note_fault(string msg);
      faults++;
      if (faults <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Compare one output beat with the oldest expected result.
    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        note_fault({"unexpected result: ", show(got)});
        return;
      end
      want = expected_q.pop_front();
      if (got.set_level !== want.set_level || got.level !== want.level ||
          got.panel_cmd !== want.panel_cmd || got.press_consumed !== want.press_consumed ||
          got.is_asleep !== want.is_asleep)
        note_fault({"result mismatch: expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, block and signals.
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  fade_scoreboard sb;
  int          events_sent    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_requests  = 0;
  int          holds_served   = 0;
  int          hold_left      = 0;
  logic [31:0] clock_ms       = '0;
  logic        vbus_now       = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  display_idle_fade_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: every beat taken on either channel goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_event(in_data_i);
    end
  end

  // Watchdog.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------

  // Offer one event beat, after a random gap, and wait until it is taken.
  task automatic put_event(logic [2:0] op, logic [31:0] stamp, logic vbus);
    in_item_t beat;
    beat.op      = op;
    beat.now_ms  = stamp;
    beat.vbus_in = vbus;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    events_sent++;
  endtask

  // Wait until every event has produced its result and the block is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.results_seen < events_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Write all registers; unused upper data bits carry junk.
  task automatic apply_settings(fade_cfg_t c);
    put_reg(CFG_TIMEOUT, c.timeout);
    put_reg(CFG_FULL, ($urandom() & 32'hFFFF_FF00) | 32'(c.full));
    put_reg(CFG_FADE_OUT, ($urandom() & 32'hFFFF_0000) | 32'(c.fade_out));
    put_reg(CFG_FADE_IN, ($urandom() & 32'hFFFF_0000) | 32'(c.fade_in));
    put_reg(CFG_FADE_STEP, ($urandom() & 32'hFFFF_0000) | 32'(c.step_gap));
    put_reg(CFG_SLEEP_USB, ($urandom() & 32'hFFFF_FFFE) | 32'(c.usb_sleep));
    put_reg(CFG_SPARE, $urandom());
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.cfg = c;
  endtask

  // Idling patterns: none, sender only, receiver only, both.
  task automatic set_idling(int sel);
    @(negedge clk_i);
    case (sel)
      1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
      3:       begin send_idle_pct = 21; recv_stall_pct = 21; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
    @(posedge clk_i);
  endtask

  task automatic request_hold();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    hold_requests++;
    @(posedge clk_i);
  endtask

  // Random event stream: mostly ticks with advancing time, some wakes and
  // sleeps, an occasional jump of the clock and a few undefined codes.
  task automatic run_items(int n, int gap_max, bit squeeze);
    int          r;
    logic [2:0]  op;
    for (int k = 0; k < n; k++) begin
      if (squeeze && k == n / 4) request_hold();
      if ($urandom_range(0, 99) < 4) vbus_now = ~vbus_now;
      r = $urandom_range(0, 99);
      if (r < 3) clock_ms = $urandom();
      else if (r >= 8) clock_ms = clock_ms + 32'($urandom_range(0, gap_max));
      r = $urandom_range(0, 99);
      if (r < 70) op = OP_TICK;
      else if (r < 76) op = OP_ACTIVITY;
      else if (r < 82) op = OP_WAKE_PRESS;
      else if (r < 87) op = OP_WAKE;
      else if (r < 93) op = OP_SLEEP;
      else if (r < 96) op = OP_INIT;
      else if (r < 98) op = OP_SPARE_6;
      else op = OP_SPARE_7;
      put_event(op, clock_ms, vbus_now);
    end
  endtask

  task automatic phase(logic [31:0] timeout, logic [7:0] full, logic [15:0] fade_out,
                       logic [15:0] fade_in, logic [15:0] step_gap, logic usb_sleep,
                       int gap_max, int idle_sel, bit squeeze);
    fade_cfg_t c;
    c.timeout   = timeout;
    c.full      = full;
    c.fade_out  = fade_out;
    c.fade_in   = fade_in;
    c.step_gap  = step_gap;
    c.usb_sleep = usb_sleep;
    drain();
    apply_settings(c);
    set_idling(idle_sel);
    run_items(PHASE_ITEMS, gap_max, squeeze);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk with the reset register values.
    put_event(OP_INIT, 32'd0, 1'b0);
    put_event(OP_TICK, 32'd100, 1'b0);
    put_event(OP_TICK, 32'd30000, 1'b0);        // timeout reached, fade-out starts
    put_event(OP_TICK, 32'd30010, 1'b0);        // inside the step spacing
    put_event(OP_TICK, 32'd30260, 1'b0);        // interpolated level
    put_event(OP_WAKE_PRESS, 32'd30270, 1'b0);  // press swallowed by the wake
    put_event(OP_WAKE_PRESS, 32'd30271, 1'b0);  // press during fade-in
    put_event(OP_TICK, 32'd30400, 1'b0);
    put_event(OP_TICK, 32'd30600, 1'b0);        // fade-in complete
    put_event(OP_SLEEP, 32'd30700, 1'b0);
    put_event(OP_SLEEP, 32'd30701, 1'b0);       // already going dark
    put_event(OP_TICK, 32'd31300, 1'b0);        // fade-out done, panel sleep-in
    put_event(OP_TICK, 32'd31400, 1'b1);        // USB does not undo a manual sleep
    put_event(OP_ACTIVITY, 32'd31500, 1'b0);    // panel sleep-out
    put_event(OP_TICK, 32'd31800, 1'b0);
    put_event(OP_SPARE_6, 32'hFFFF_FFFF, 1'b1);
    put_event(OP_SPARE_7, 32'd0, 1'b1);
    put_event(OP_TICK, 32'hFFFF_FFF0, 1'b0);
    put_event(OP_TICK, 32'hFFFF_FFFF, 1'b1);    // USB wakes a fade-out
    put_event(OP_WAKE, 32'h0000_0010, 1'b0);
    put_event(OP_TICK, 32'h0000_0020, 1'b0);    // time difference across the wrap
    put_event(OP_TICK, 32'h0000_1000, 1'b0);
    put_event(OP_INIT, 32'h0000_1234, 1'b1);
    clock_ms = 32'h0000_1234;

    // Random phases over a spread of register settings.
    phase(32'd30000, 8'd255, 16'd500, 16'd200, 16'd20, 1'b0, 3000, 0, 1'b0);
    phase(32'd100, 8'd255, 16'd60, 16'd40, 16'd5, 1'b0, 30, 1, 1'b0);
    phase(32'd0, 8'd200, 16'd100, 16'd100, 16'd10, 1'b1, 50, 2, 1'b0);
    phase(32'd50, 8'd0, 16'd80, 16'd80, 16'd10, 1'b0, 30, 3, 1'b0);
    phase(32'd40, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0, 30, 0, 1'b1);
    phase(32'd200, 8'd128, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 20000, 1, 1'b0);
    phase(32'hFFFF_FFFF, 8'd1, 16'd300, 16'd300, 16'd0, 1'b1, 40, 2, 1'b0);
    phase(32'd20, 8'd255, 16'd255, 16'd37, 16'd0, 1'b0, 25, 3, 1'b0);
    phase(32'd1, 8'd77, 16'd1000, 16'd3, 16'd1, 1'b1, 10, 0, 1'b0);
    phase(32'($urandom_range(0, 400)), 8'($urandom_range(0, 255)),
          16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
          16'($urandom_range(0, 40)), 1'($urandom_range(0, 1)), 100, 1, 1'b0);
    phase(32'($urandom_range(0, 400)), 8'($urandom_range(0, 255)),
          16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
          16'($urandom_range(0, 40)), 1'($urandom_range(0, 1)), 100, 3, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.faults == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0d expected results never arrived", sb.expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== display_idle_fade_controller.f =====
+incdir+rtl/core
rtl/core/difc_pkg.sv
rtl/core/difc_div.sv
rtl/core/difc_datapath.sv
rtl/core/difc_ctrl.sv
rtl/core/display_idle_fade_controller.sv
test/tb_top.sv
